/* rtl/dq_pkg.sv */
// Shared types and constants of the double-ended queue.
package dq_pkg;

  localparam int unsigned FIELD_W    = 64;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned OUT_DATA_W = 200;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD_FRONT = 3'd0,
    MODE_ADD_BACK  = 3'd1,
    MODE_REM_FRONT = 3'd2,
    MODE_REM_BACK  = 3'd3,
    MODE_CLEAR     = 3'd4
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_REMOVED = 2'd1,
    STAT_EMPTY   = 2'd2,
    STAT_FULL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_FETCH = 2'b10
  } state_e;

  typedef struct packed {
    status_e              status;
    logic [FIELD_W-1:0]   removed_value;
    logic [FIELD_W-1:0]   front_value;
    logic [FIELD_W-1:0]   back_value;
    logic [COUNT_W-1:0]   stored_count;
  } result_t;

endpackage

/* rtl/dq_ram.sv */
// Generic single-port RAM with registered read data.
module dq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/dq_ctrl.sv */
// Pointer, count and end-entry cache control of the double-ended queue.
module dq_ctrl #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned ENTRY_BITS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  dq_pkg::mode_e                 mode_i,
  input  logic [dq_pkg::FIELD_W-1:0]    value_i,
  input  logic                          out_free_i,
  output logic                          res_valid_o,
  output dq_pkg::result_t               res_o,
  output logic                          ram_we_o,
  output logic [$clog2(DEPTH)-1:0]      ram_addr_o,
  output logic [ENTRY_BITS-1:0]         ram_wdata_o,
  input  logic [ENTRY_BITS-1:0]         ram_rdata_i
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] idx);
    return (idx == LAST_IDX) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] idx);
    return (idx == '0) ? LAST_IDX : idx - 1'b1;
  endfunction

  dq_pkg::state_e          state_q, state_d;
  logic [IW-1:0]           front_idx_q, front_idx_d;
  logic [IW-1:0]           back_idx_q, back_idx_d;
  logic [CW-1:0]           count_q, count_d;
  logic [ENTRY_BITS-1:0]   front_val_q, front_val_d;
  logic [ENTRY_BITS-1:0]   back_val_q, back_val_d;
  dq_pkg::status_e         status_q, status_d;
  logic [ENTRY_BITS-1:0]   removed_q, removed_d;
  logic                    fetch_front_q, fetch_front_d;

  logic                    accept;
  logic                    fetch_start;
  logic                    is_full;
  logic                    is_empty;
  logic [ENTRY_BITS-1:0]   value;
  dq_pkg::status_e         status_now;
  logic [ENTRY_BITS-1:0]   removed_now;

  assign in_ready_o = (state_q == dq_pkg::S_IDLE) && out_free_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_full    = (count_q == FULL_CNT);
  assign is_empty   = (count_q == '0);
  assign value      = value_i[ENTRY_BITS-1:0];

  always_comb begin
    state_d       = state_q;
    front_idx_d   = front_idx_q;
    back_idx_d    = back_idx_q;
    count_d       = count_q;
    front_val_d   = front_val_q;
    back_val_d    = back_val_q;
    status_d      = status_q;
    removed_d     = removed_q;
    fetch_front_d = fetch_front_q;
    status_now    = dq_pkg::STAT_OK;
    removed_now   = '0;
    fetch_start   = 1'b0;
    ram_we_o      = 1'b0;
    ram_addr_o    = front_idx_q;
    ram_wdata_o   = value;

    unique case (state_q)
      dq_pkg::S_IDLE: begin
        if (accept) begin
          unique case (mode_i)
            dq_pkg::MODE_ADD_FRONT: begin
              if (is_full) begin
                status_now = dq_pkg::STAT_FULL;
              end else begin
                front_idx_d = idx_dec(front_idx_q);
                ram_we_o    = 1'b1;
                ram_addr_o  = idx_dec(front_idx_q);
                count_d     = count_q + 1'b1;
                front_val_d = value;
                if (is_empty) begin
                  back_val_d = value;
                end
              end
            end
            dq_pkg::MODE_ADD_BACK: begin
              if (is_full) begin
                status_now = dq_pkg::STAT_FULL;
              end else begin
                back_idx_d = idx_inc(back_idx_q);
                ram_we_o   = 1'b1;
                ram_addr_o = idx_inc(back_idx_q);
                count_d    = count_q + 1'b1;
                back_val_d = value;
                if (is_empty) begin
                  front_val_d = value;
                end
              end
            end
            dq_pkg::MODE_REM_FRONT: begin
              if (is_empty) begin
                status_now = dq_pkg::STAT_EMPTY;
              end else begin
                status_now    = dq_pkg::STAT_REMOVED;
                removed_now   = front_val_q;
                front_idx_d   = idx_inc(front_idx_q);
                count_d       = count_q - 1'b1;
                // fetch the new front entry when one is left
                ram_addr_o    = idx_inc(front_idx_q);
                fetch_start   = (count_q != CW'(1));
                fetch_front_d = 1'b1;
              end
            end
            dq_pkg::MODE_REM_BACK: begin
              if (is_empty) begin
                status_now = dq_pkg::STAT_EMPTY;
              end else begin
                status_now    = dq_pkg::STAT_REMOVED;
                removed_now   = back_val_q;
                back_idx_d    = idx_dec(back_idx_q);
                count_d       = count_q - 1'b1;
                ram_addr_o    = idx_dec(back_idx_q);
                fetch_start   = (count_q != CW'(1));
                fetch_front_d = 1'b0;
              end
            end
            dq_pkg::MODE_CLEAR: begin
              count_d     = '0;
              front_idx_d = '0;
              back_idx_d  = LAST_IDX;
            end
            default: begin
            end
          endcase
          status_d  = status_now;
          removed_d = removed_now;
          if (fetch_start) begin
            state_d = dq_pkg::S_FETCH;
          end
        end
      end
      dq_pkg::S_FETCH: begin
        if (fetch_front_q) begin
          front_val_d = ram_rdata_i;
        end else begin
          back_val_d = ram_rdata_i;
        end
        state_d = dq_pkg::S_IDLE;
      end
      default: begin
        state_d = dq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    res_valid_o = (accept && !fetch_start) || (state_q == dq_pkg::S_FETCH);
    if (state_q == dq_pkg::S_FETCH) begin
      res_o.status        = status_q;
      res_o.removed_value = dq_pkg::FIELD_W'(removed_q);
    end else begin
      res_o.status        = status_now;
      res_o.removed_value = dq_pkg::FIELD_W'(removed_now);
    end
    res_o.front_value  = (count_d != '0) ? dq_pkg::FIELD_W'(front_val_d) : '0;
    res_o.back_value   = (count_d != '0) ? dq_pkg::FIELD_W'(back_val_d) : '0;
    res_o.stored_count = dq_pkg::COUNT_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dq_pkg::S_IDLE;
      front_idx_q <= '0;
      back_idx_q  <= LAST_IDX;
      count_q     <= '0;
    end else begin
      state_q     <= state_d;
      front_idx_q <= front_idx_d;
      back_idx_q  <= back_idx_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_val_q   <= front_val_d;
    back_val_q    <= back_val_d;
    status_q      <= status_d;
    removed_q     <= removed_d;
    fetch_front_q <= fetch_front_d;
  end

endmodule

/* rtl/double_ended_queue.sv */
// Top level of the double-ended queue: stream ports, result register, slot RAM.
//
//  Channel   Dir  Handshake             Payload
//  s_axis    in   tvalid/tready         tuser: mode; tdata: entry_value
//  m_axis    out  tvalid/tready         tuser: status; tdata: removed, front,
//                                       back, stored_count
//
// An add, a clear, a rejected add, an empty removal or a removal that leaves
// the queue empty is done in the idle state; a removal that leaves entries
// then waits in S_FETCH on the slot RAM read of the new front or back entry.
// Front and back entries are cached in registers, so the RAM is read only
// after a removal. Results sit in an output register, and a new transaction
// is taken while the held result leaves in the same cycle.
// Reset clears pointers, count and control; no clearing pass over the RAM.
// A stalled master side holds the result and blocks further input.
module double_ended_queue #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned ENTRY_BITS = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [dq_pkg::FIELD_W-1:0]      s_axis_tdata,  // [63:0] entry_value
  input  logic [dq_pkg::MODE_W-1:0]       s_axis_tuser,  // [2:0] mode
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [63:0] removed_value, [127:64] front_value, [191:128] back_value,
  // [196:192] stored_count, [199:197] zero
  output logic [dq_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic [dq_pkg::STATUS_W-1:0]     m_axis_tuser   // [1:0] status
);

  localparam int unsigned IW = $clog2(DEPTH);

  logic                    out_valid_q, out_valid_d;
  dq_pkg::result_t         out_res_q, out_res_d;
  logic                    out_free;
  logic                    res_valid;
  dq_pkg::result_t         res;
  logic                    ram_we;
  logic [IW-1:0]           ram_addr;
  logic [ENTRY_BITS-1:0]   ram_wdata;
  logic [ENTRY_BITS-1:0]   ram_rdata;

  // The register is free when empty or when its transaction completes now.
  assign out_free = !out_valid_q || m_axis_tready;

  dq_ctrl #(
    .DEPTH      (DEPTH),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .mode_i      (dq_pkg::mode_e'(s_axis_tuser)),
    .value_i     (s_axis_tdata),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata)
  );

  dq_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Load a new result, or drop the held one once it is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
      out_res_d   = res;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.status;
  assign m_axis_tdata  = {3'b000,
                          out_res_q.stored_count,
                          out_res_q.back_value,
                          out_res_q.front_value,
                          out_res_q.removed_value};

endmodule

/* tb/sv/double_ended_queue_tb.sv */
// Self-checking testbench of the double-ended queue, with its own ring model.
`timescale 1ns / 1ps

module double_ended_queue_tb;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned ENTRY_BITS = 64;
  // Highest code the mode field can carry; codes above MODE_CLEAR are unused.
  localparam int unsigned MODE_LAST  = (1 << dq_pkg::MODE_W) - 1;
  localparam int unsigned IDLE_PCT   = 9;
  localparam int unsigned MAX_PRINTS = 40;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [dq_pkg::FIELD_W-1:0]    s_axis_tdata;   // [63:0] entry_value
  logic [dq_pkg::MODE_W-1:0]     s_axis_tuser;   // [2:0] mode
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  // [63:0] removed_value, [127:64] front_value, [191:128] back_value,
  // [196:192] stored_count, [199:197] zero
  logic [dq_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [dq_pkg::STATUS_W-1:0]   m_axis_tuser;   // [1:0] status

  double_ended_queue #(
    .DEPTH      (DEPTH),
    .ENTRY_BITS (ENTRY_BITS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Mirror of the ring: slot contents, front slot and fill level.
  logic [dq_pkg::FIELD_W-1:0] ring_slots [DEPTH];
  int unsigned                ring_head;
  int unsigned                ring_fill;

  // Predicted results, oldest first, waiting for their transaction on the master side.
  dq_pkg::result_t pending_results [$];

  int unsigned mismatches;
  int unsigned cmds_sent;
  int unsigned results_seen;
  int unsigned status_seen [4];
  int unsigned peak_fill;
  bit          quiet_mode;   // suspend random idling on both sides

  // Clock: 10 ns period.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Pick whether a side idles this cycle.
  function automatic bit take_gap();
    return !quiet_mode && ($urandom_range(0, 99) < IDLE_PCT);
  endfunction

  // Advance the ring mirror by one command and return the result it must produce.
  function automatic dq_pkg::result_t step_deque(logic [dq_pkg::MODE_W-1:0] cmd,
                                                 logic [dq_pkg::FIELD_W-1:0] value);
    dq_pkg::result_t res;
    int unsigned     slot;
    res = '0;
    res.status = dq_pkg::STAT_OK;
    case (cmd)
      dq_pkg::MODE_ADD_FRONT: begin
        if (ring_fill >= DEPTH) begin
          res.status = dq_pkg::STAT_FULL;
        end else begin
          ring_head = (ring_head + DEPTH - 1) % DEPTH;
          ring_slots[ring_head] = value;
          ring_fill++;
        end
      end
      dq_pkg::MODE_ADD_BACK: begin
        if (ring_fill >= DEPTH) begin
          res.status = dq_pkg::STAT_FULL;
        end else begin
          ring_slots[(ring_head + ring_fill) % DEPTH] = value;
          ring_fill++;
        end
      end
      dq_pkg::MODE_REM_FRONT: begin
        if (ring_fill == 0) begin
          res.status = dq_pkg::STAT_EMPTY;
        end else begin
          res.removed_value = ring_slots[ring_head];
          ring_head = (ring_head + 1) % DEPTH;
          ring_fill--;
          res.status = dq_pkg::STAT_REMOVED;
        end
      end
      dq_pkg::MODE_REM_BACK: begin
        if (ring_fill == 0) begin
          res.status = dq_pkg::STAT_EMPTY;
        end else begin
          slot = (ring_head + ring_fill - 1) % DEPTH;
          res.removed_value = ring_slots[slot];
          ring_fill--;
          res.status = dq_pkg::STAT_REMOVED;
        end
      end
      dq_pkg::MODE_CLEAR: begin
        // Slot contents stay; only the pointers drop.
        ring_fill = 0;
        ring_head = 0;
      end
      default: ;  // unused codes leave everything alone
    endcase
    if (ring_fill > 0) begin
      res.front_value = ring_slots[ring_head];
      res.back_value  = ring_slots[(ring_head + ring_fill - 1) % DEPTH];
    end
    res.stored_count = ring_fill[dq_pkg::COUNT_W-1:0];
    if (ring_fill > peak_fill) peak_fill = ring_fill;
    return res;
  endfunction

  // Print one mismatch line (the first few only) and count it.
  task automatic report_mismatch(string what, logic [dq_pkg::FIELD_W-1:0] got,
                                 logic [dq_pkg::FIELD_W-1:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS) begin
      $display("[%0t] mismatch in %s after result %0d: got %h, want %h",
               $realtime, what, results_seen, got, want);
    end
  endtask

  // Compare one accepted result with the oldest prediction.
  task automatic check_result();
    dq_pkg::result_t want;
    results_seen++;
    status_seen[m_axis_tuser]++;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected result", {62'd0, m_axis_tuser}, '0);
    end else begin
      want = pending_results[0];
      pending_results.delete(0);
      if (m_axis_tuser !== want.status)
        report_mismatch("status", {62'd0, m_axis_tuser}, {62'd0, want.status});
      if (m_axis_tdata[63:0] !== want.removed_value)
        report_mismatch("removed_value", m_axis_tdata[63:0], want.removed_value);
      if (m_axis_tdata[127:64] !== want.front_value)
        report_mismatch("front_value", m_axis_tdata[127:64], want.front_value);
      if (m_axis_tdata[191:128] !== want.back_value)
        report_mismatch("back_value", m_axis_tdata[191:128], want.back_value);
      if (m_axis_tdata[196:192] !== want.stored_count)
        report_mismatch("stored_count", {59'd0, m_axis_tdata[196:192]},
                        {59'd0, want.stored_count});
      if (m_axis_tdata[199:197] !== 3'd0)
        report_mismatch("padding", {61'd0, m_axis_tdata[199:197]}, '0);
    end
  endtask

  // Master side: check every accepted result, then decide the next tready.
  // Reading right after the edge sees the values the flops held at that edge.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_result();
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !take_gap();
    end
  end

  // Send one command on the slave side. Call it right after a rising edge;
  // it returns in the step of the edge that accepted the transaction, with
  // tvalid still high so that back-to-back commands follow without a gap.
  task automatic send_cmd(logic [dq_pkg::MODE_W-1:0] cmd, logic [dq_pkg::FIELD_W-1:0] value);
    while (take_gap()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.insert(pending_results.size(), step_deque(cmd, value));
    cmds_sent++;
  endtask

  function automatic logic [dq_pkg::FIELD_W-1:0] rand_entry();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Removals from an empty ring and the unused command codes.
  task automatic test_empty_and_unused();
    send_cmd(dq_pkg::MODE_REM_FRONT, '1);
    send_cmd(dq_pkg::MODE_REM_BACK, '1);
    for (int unsigned m = dq_pkg::MODE_CLEAR + 1; m <= MODE_LAST; m++)
      send_cmd(dq_pkg::MODE_W'(m), '1);
  endtask

  // Fill the ring from both ends, push on the full ring, remove at each end and clear.
  task automatic test_full_ring();
    for (int unsigned i = 0; i < DEPTH; i++) begin
      logic [dq_pkg::FIELD_W-1:0] v;
      v = (i == 0) ? '1 : (i == 1) ? '0 : (64'h1 << (4 * i)) | i;
      send_cmd(i[0] ? dq_pkg::MODE_ADD_BACK : dq_pkg::MODE_ADD_FRONT, v);
    end
    send_cmd(dq_pkg::MODE_ADD_FRONT, 64'h5555_5555_5555_5555);
    send_cmd(dq_pkg::MODE_ADD_BACK, 64'hAAAA_AAAA_AAAA_AAAA);
    send_cmd(dq_pkg::MODE_REM_BACK, '0);
    send_cmd(dq_pkg::MODE_REM_FRONT, '0);
    send_cmd(dq_pkg::MODE_CLEAR, '1);
  endtask

  // Random traffic in segments, each with its own lean toward adds or removals,
  // so the fill level sweeps between empty and full many times.
  task automatic test_random_traffic(int unsigned segments, int unsigned seg_len);
    int unsigned add_pct;
    int unsigned r;
    for (int unsigned s = 0; s < segments; s++) begin
      add_pct    = $urandom_range(15, 85);
      quiet_mode = (s == segments / 3);
      for (int unsigned k = 0; k < seg_len; k++) begin
        r = $urandom_range(0, 99);
        if (r < 2) begin
          send_cmd(dq_pkg::MODE_CLEAR, rand_entry());
        end else if (r < 5) begin
          send_cmd(dq_pkg::MODE_W'($urandom_range(dq_pkg::MODE_CLEAR + 1, MODE_LAST)),
                   rand_entry());
        end else if ($urandom_range(0, 99) < add_pct) begin
          send_cmd($urandom_range(0, 1) ? dq_pkg::MODE_ADD_BACK : dq_pkg::MODE_ADD_FRONT,
                   rand_entry());
        end else begin
          send_cmd($urandom_range(0, 1) ? dq_pkg::MODE_REM_BACK : dq_pkg::MODE_REM_FRONT,
                   rand_entry());
        end
      end
    end
    quiet_mode = 1'b0;
  endtask

  initial begin
    int unsigned drain_cycles;
    mismatches    = 0;
    cmds_sent     = 0;
    results_seen  = 0;
    peak_fill     = 0;
    quiet_mode    = 1'b0;
    status_seen   = '{default: 0};
    ring_head     = 0;
    ring_fill     = 0;
    ring_slots    = '{default: '0};
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= dq_pkg::MODE_ADD_FRONT;
    m_axis_tready <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_and_unused();
    test_full_ring();
    test_random_traffic(16, 100);
    s_axis_tvalid <= 1'b0;

    // Drain outstanding results, then let the pipeline settle.
    drain_cycles = 0;
    while (pending_results.size() != 0 && drain_cycles < 10000) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (8) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      report_mismatch("results never arrived", 64'(pending_results.size()), '0);
    end

    $display("Ran %0d commands, checked %0d results, ring filled up to %0d of %0d",
             cmds_sent, results_seen, peak_fill, DEPTH);
    $display("Status counts: ok %0d, removed %0d, empty %0d, full %0d; mismatches %0d",
             status_seen[dq_pkg::STAT_OK], status_seen[dq_pkg::STAT_REMOVED],
             status_seen[dq_pkg::STAT_EMPTY], status_seen[dq_pkg::STAT_FULL], mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* files.f */
rtl/dq_pkg.sv
rtl/dq_ram.sv
rtl/dq_ctrl.sv
rtl/double_ended_queue.sv
tb/sv/double_ended_queue_tb.sv
